/* rtl/iiss_pkg.sv */
// shared constants and types for the integral image sum and square block
package iiss_pkg;

  localparam int PIXEL_W      = 16;
  localparam int AREA_W       = 36;
  localparam int AREA_SQ_W    = 51;
  localparam int SIZE_W       = 11;
  localparam int SQUARE_W     = 31;   // largest square is 2**30
  localparam int CFG_INDEX_W  = 1;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam logic [SIZE_W-1:0] FRAME_WIDTH_RESET  = SIZE_W'(1024);
  localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RESET = SIZE_W'(1024);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

endpackage

/* rtl/iiss_if.sv */
// stream interfaces for pixels in and table entries out
interface iiss_pixel_if
  import iiss_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic signed [PIXEL_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface iiss_result_if
  import iiss_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic signed [AREA_W-1:0]   area_sum;
  logic        [AREA_SQ_W-1:0] area_square_sum;
  logic                       row_end;
  logic                       frame_end;

  modport source (output valid, output area_sum, output area_square_sum,
                  output row_end, output frame_end, input ready);
  modport sink   (input valid, input area_sum, input area_square_sum,
                  input row_end, input frame_end, output ready);
endinterface

/* rtl/integral_image_sum_and_square.sv */
// top level: summed-area table and squared summed-area table of a pixel stream
//
// Pixels arrive in raster order, one per transfer, and for each one the block
// returns the summed-area entry and the summed-area entry of squared pixels,
// plus row and frame end marks. It takes one pixel every clock cycle; a pixel
// transferred in passes the pixel, square and line store stages to the output
// register, and the pipeline only stalls when the result side holds ready low.
// That rate is set by the two line stores, each a ram with one write and one
// read port: every pixel reads the entry above it once and writes its own
// entry once. When consecutive pixels hit the same column (very narrow frames)
// the entry still in flight is forwarded. The line stores are not cleared; the
// first row of a frame discards their data. frame_width and frame_height must
// be written only while the stream is idle; the block does not enforce this.
// Zero acts as one; values above MAX_WIDTH or MAX_HEIGHT act as that maximum.
module integral_image_sum_and_square
  import iiss_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]      cfg_data,
  iiss_pixel_if.sink             pix,
  iiss_result_if.source          res
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int RSW = PIXEL_W + CW;     // running row sum, signed
  localparam int RQW = SQUARE_W + CW;    // running row square sum
  localparam logic [SIZE_W+1:0] MAX_W_EXT = (SIZE_W+2)'(MAX_WIDTH);
  localparam logic [SIZE_W+1:0] MAX_H_EXT = (SIZE_W+2)'(MAX_HEIGHT);

  // per-pixel position info carried down the pipeline
  typedef struct packed {
    logic [CW-1:0] col;
    logic          first_col;
    logic          row_nz;
    logic          row_end;
    logic          frame_end;
  } pos_t;

  // configuration registers
  logic [SIZE_W-1:0] frame_width;
  logic [SIZE_W-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // last column and row index after clamping the size registers
  logic [CW-1:0] last_col;
  logic [RW-1:0] last_row;

  always_comb begin
    if (frame_width == '0) begin
      last_col = '0;
    end else if ({2'b00, frame_width} > MAX_W_EXT) begin
      last_col = CW'(MAX_WIDTH - 1);
    end else begin
      last_col = CW'(frame_width - SIZE_W'(1));
    end
    if (frame_height == '0) begin
      last_row = '0;
    end else if ({2'b00, frame_height} > MAX_H_EXT) begin
      last_row = RW'(MAX_HEIGHT - 1);
    end else begin
      last_row = RW'(frame_height - SIZE_W'(1));
    end
  end

  // pipeline handshake: each stage moves when the next one is free
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic s4_ready, s3_free, s2_free, s1_free;
  logic s2_adv, s3_adv;
  logic in_xfer;

  assign s4_ready  = !s4_valid || res.ready;
  assign s3_free   = !s3_valid || s4_ready;
  assign s2_free   = !s2_valid || s3_free;
  assign s1_free   = !s1_valid || s2_free;
  assign s3_adv    = s3_valid && s4_ready;
  assign s2_adv    = s2_valid && s3_free;
  assign pix.ready = s1_free;
  assign in_xfer   = pix.valid && s1_free;

  // column and row counters, stepped on each input transfer
  logic [CW-1:0] column_count;
  logic [RW-1:0] row_count;
  pos_t          in_pos;

  always_comb begin
    in_pos.col       = column_count;
    in_pos.first_col = (column_count == '0);
    in_pos.row_nz    = (row_count != '0);
    in_pos.row_end   = (column_count >= last_col);
    in_pos.frame_end = in_pos.row_end && (row_count >= last_row);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_xfer) begin
      if (in_pos.row_end) begin
        column_count <= '0;
        if (in_pos.frame_end) begin
          row_count <= '0;
        end else begin
          row_count <= row_count + RW'(1);
        end
      end else begin
        column_count <= column_count + CW'(1);
      end
    end
  end

  // stage 1: pixel register
  logic signed [PIXEL_W-1:0] s1_pixel;
  pos_t                      s1_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_pixel <= pix.pixel;
      s1_pos   <= in_pos;
    end
  end

  // stage 2: square of the pixel
  logic signed [PIXEL_W-1:0]   s2_pixel;
  logic        [SQUARE_W-1:0]  s2_sq;
  pos_t                        s2_pos;
  logic signed [2*PIXEL_W-1:0] s1_prod;

  assign s1_prod = s1_pixel * s1_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2_pixel <= s1_pixel;
      s2_sq    <= s1_prod[SQUARE_W-1:0];
      s2_pos   <= s1_pos;
    end
  end

  // running row sums, updated as a pixel moves into stage 3
  logic signed [RSW-1:0] row_sum, row_sum_next;
  logic        [RQW-1:0] row_sq,  row_sq_next;
  logic signed [RSW-1:0] s2_pixel_ext;
  logic        [RQW-1:0] s2_sq_ext;

  assign s2_pixel_ext = {{(RSW-PIXEL_W){s2_pixel[PIXEL_W-1]}}, s2_pixel};
  assign s2_sq_ext    = {{(RQW-SQUARE_W){1'b0}}, s2_sq};

  always_comb begin
    if (s2_pos.first_col) begin
      // a new row restarts at the pixel
      row_sum_next = s2_pixel_ext;
      row_sq_next  = s2_sq_ext;
    end else begin
      row_sum_next = row_sum + s2_pixel_ext;
      row_sq_next  = row_sq + s2_sq_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_sum <= '0;
      row_sq  <= '0;
    end else if (s2_adv) begin
      row_sum <= row_sum_next;
      row_sq  <= row_sq_next;
    end
  end

  // stage 3: add the entry above and write the new entry back
  logic signed [RSW-1:0]       s3_rsum;
  logic        [RQW-1:0]       s3_rsq;
  pos_t                        s3_pos;
  logic                        s3_fwd;
  logic        [AREA_W-1:0]    last_area;
  logic        [AREA_SQ_W-1:0] last_sq;
  logic        [AREA_W-1:0]    above_area_ram, above_area;
  logic        [AREA_SQ_W-1:0] above_sq_ram,   above_sq;
  logic        [AREA_W-1:0]    area;
  logic        [AREA_SQ_W-1:0] area_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_free) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s3_rsum <= row_sum_next;
      s3_rsq  <= row_sq_next;
      s3_pos  <= s2_pos;
      // the pixel leaving stage 3 right now writes the same column
      s3_fwd  <= s3_valid && (s3_pos.col == s2_pos.col);
    end
  end

  // the line stores
  iiss_ram #(
    .WIDTH (AREA_W),
    .DEPTH (MAX_WIDTH)
  ) u_prior_row_sums (
    .clk   (clk),
    .we    (s3_adv),
    .waddr (s3_pos.col),
    .wdata (area),
    .re    (s2_adv),
    .raddr (s2_pos.col),
    .rdata (above_area_ram)
  );

  iiss_ram #(
    .WIDTH (AREA_SQ_W),
    .DEPTH (MAX_WIDTH)
  ) u_prior_row_square_sums (
    .clk   (clk),
    .we    (s3_adv),
    .waddr (s3_pos.col),
    .wdata (area_sq),
    .re    (s2_adv),
    .raddr (s2_pos.col),
    .rdata (above_sq_ram)
  );

  always_comb begin
    if (!s3_pos.row_nz) begin
      // first row of a frame, nothing above
      above_area = '0;
      above_sq   = '0;
    end else if (s3_fwd) begin
      above_area = last_area;
      above_sq   = last_sq;
    end else begin
      above_area = above_area_ram;
      above_sq   = above_sq_ram;
    end
    area    = {{(AREA_W-RSW){s3_rsum[RSW-1]}}, s3_rsum} + above_area;
    area_sq = {{(AREA_SQ_W-RQW){1'b0}}, s3_rsq} + above_sq;
  end

  // copy of the last entry written, for back-to-back hits on one column
  always_ff @(posedge clk) begin
    if (s3_adv) begin
      last_area <= area;
      last_sq   <= area_sq;
    end
  end

  // stage 4: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (s4_ready) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_adv) begin
      res.area_sum        <= area;
      res.area_square_sum <= area_sq;
      res.row_end         <= s3_pos.row_end;
      res.frame_end       <= s3_pos.frame_end;
    end
  end

  assign res.valid = s4_valid;

endmodule

/* rtl/iiss_ram.sv */
// generic simple dual-port ram, one write and one registered read port
module iiss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
